// ----- rtl/core/vibalu_pkg.sv -----
// Package for the integer binary ALU: operation codes, queue word and pipeline types.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package vibalu_pkg;

    localparam int DATA_WIDTH_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;
    localparam logic [5:0] SHIFT_MASK = 6'h3f;

    localparam logic [4:0] K_ADD    = 5'd0;
    localparam logic [4:0] K_SUB    = 5'd1;
    localparam logic [4:0] K_MUL    = 5'd2;
    localparam logic [4:0] K_INTDIV = 5'd3;
    localparam logic [4:0] K_DIVMOD = 5'd4;
    localparam logic [4:0] K_REM    = 5'd5;
    localparam logic [4:0] K_MOD    = 5'd6;
    localparam logic [4:0] K_EQ     = 5'd7;
    localparam logic [4:0] K_NEQ    = 5'd8;
    localparam logic [4:0] K_IS     = 5'd9;
    localparam logic [4:0] K_LT     = 5'd10;
    localparam logic [4:0] K_LTE    = 5'd11;
    localparam logic [4:0] K_GT     = 5'd12;
    localparam logic [4:0] K_GTE    = 5'd13;
    localparam logic [4:0] K_AND    = 5'd14;
    localparam logic [4:0] K_OR     = 5'd15;
    localparam logic [4:0] K_XOR    = 5'd16;
    localparam logic [4:0] K_LSH    = 5'd17;
    localparam logic [4:0] K_RSH    = 5'd18;

    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] a;
        logic [63:0] b;
        logic        any_null;
        logic        both_null;
        logic        div_op;
    } qword_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic        a_neg;
        logic [63:0] b;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] quo;
        logic [63:0] res;
        logic [63:0] pl;
        logic [31:0] p1;
        logic [31:0] p2;
        logic        isnull;
        logic        status;
        logic        dv;
    } pipe_t;

    function automatic logic [63:0] sx(input logic [63:0] v, input int w);
        logic [63:0] mask;
        logic [63:0] sign;
        mask = ~64'd0 >> (64 - w);
        sign = 64'd1 << (w - 1);
        return ((v & mask) ^ sign) - sign;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vibalu_front.sv -----
// Front end: takes commands, sign-extends operands and classifies each operation.
// Depends on vibalu_pkg.
`default_nettype none

module vibalu_front
    import vibalu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic        start,
    input  wire logic        full,
    input  wire logic [4:0]  kind,
    input  wire logic [63:0] left_operand,
    input  wire logic [63:0] right_operand,
    input  wire logic        left_is_null,
    input  wire logic        right_is_null,
    output logic             push,
    output qword_t           word
);

    always_comb
    begin
        push           = start && !full;
        word.kind      = kind;
        word.a         = sx(left_operand, DATA_WIDTH);
        word.b         = sx(right_operand, DATA_WIDTH);
        word.any_null  = left_is_null || right_is_null;
        word.both_null = left_is_null && right_is_null;
        word.div_op    = (kind == K_INTDIV) || (kind == K_DIVMOD) ||
                         (kind == K_REM) || (kind == K_MOD);
    end

endmodule

`default_nettype wire

// ----- rtl/core/vibalu_queue.sv -----
// Short queue of classified words between the front end and the execution pipeline.
// Depends on vibalu_pkg.
`default_nettype none

module vibalu_queue
    import vibalu_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  qword_t      push_word,
    input  wire logic   pop,
    output logic        full,
    output logic        empty,
    output qword_t      pop_word
);

    qword_t     mem_reg [QUEUE_DEPTH];
    logic [0:0] wr_ptr_reg;
    logic [0:0] wr_ptr_next;
    logic [0:0] rd_ptr_reg;
    logic [0:0] rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        full        = count_reg == 2'(QUEUE_DEPTH);
        empty       = count_reg == 2'd0;
        pop_word    = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/vibalu_back.sv -----
// Execution pipeline: simple operations, split multiplier and a one-bit-per-stage divider.
// Depends on vibalu_pkg.
`default_nettype none

module vibalu_back
    import vibalu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  qword_t            in_word,
    output logic              done,
    output logic [63:0]       result_value,
    output logic              result_is_null,
    output logic [63:0]       second_value,
    output logic              status
);

    pipe_t       st_reg [DATA_WIDTH + 1];
    pipe_t       st_next [DATA_WIDTH + 1];
    logic        v_reg [DATA_WIDTH + 1];
    logic        done_reg;
    logic [63:0] result_value_reg;
    logic        result_is_null_reg;
    logic [63:0] second_value_reg;
    logic        status_reg;
    logic [63:0] result_value_next;
    logic [63:0] second_value_next;

    always_comb
    begin
        logic [63:0] a;
        logic [63:0] b;
        logic [5:0]  s;
        logic [64:0] rt;
        logic [63:0] qn;
        logic [63:0] rn;
        logic [63:0] q;
        logic [63:0] r;
        logic        fl;
        pipe_t       p;
        a = in_word.a;
        b = in_word.b;
        s = b[5:0] & SHIFT_MASK;
        p = '0;
        p.kind  = in_word.kind;
        p.a_neg = a[63];
        p.b     = b;
        p.num   = a[63] ? 64'd0 - a : a;
        p.den   = b[63] ? 64'd0 - b : b;
        p.pl    = {32'd0, a[31:0]} * {32'd0, b[31:0]};
        p.p1    = a[31:0] * b[63:32];
        p.p2    = a[63:32] * b[31:0];
        if (in_word.any_null)
        begin
            case (in_word.kind)
                K_EQ, K_IS: p.res = {63'd0, in_word.both_null};
                K_NEQ:      p.res = {63'd0, !in_word.both_null};
                K_LT, K_LTE, K_GT, K_GTE: p.res = 64'd0;
                default:    p.res = 64'd0;
            endcase
            p.isnull = (in_word.kind <= K_MOD) ||
                       (in_word.kind >= K_AND && in_word.kind <= K_RSH);
        end
        else if (in_word.div_op)
        begin
            p.status = b == 64'd0;
            p.dv     = b != 64'd0;
        end
        else
        begin
            case (in_word.kind)
                K_ADD:      p.res = sx(a + b, DATA_WIDTH);
                K_SUB:      p.res = sx(a - b, DATA_WIDTH);
                K_EQ, K_IS: p.res = {63'd0, a == b};
                K_NEQ:      p.res = {63'd0, a != b};
                K_LT:       p.res = {63'd0, $signed(a) < $signed(b)};
                K_LTE:      p.res = {63'd0, $signed(a) <= $signed(b)};
                K_GT:       p.res = {63'd0, $signed(a) > $signed(b)};
                K_GTE:      p.res = {63'd0, $signed(a) >= $signed(b)};
                K_AND:      p.res = a & b;
                K_OR:       p.res = a | b;
                K_XOR:      p.res = a ^ b;
                K_LSH:      p.res = sx(a << s, DATA_WIDTH);
                K_RSH:      p.res = $unsigned($signed(a) >>> s);
                default:    p.res = 64'd0;
            endcase
        end
        st_next[0] = p;

        for (int k = 0; k < DATA_WIDTH; k++)
        begin
            p  = st_reg[k];
            rt = {p.rem, p.num[DATA_WIDTH - 1]};
            if (rt >= {1'b0, p.den})
            begin
                rt    = rt - {1'b0, p.den};
                p.quo = {p.quo[62:0], 1'b1};
            end
            else
            begin
                p.quo = {p.quo[62:0], 1'b0};
            end
            p.rem = rt[63:0];
            p.num = p.num << 1;
            if (k == 0 && p.kind == K_MUL && !p.isnull)
            begin
                p.res = sx(p.pl + {p.p1 + p.p2, 32'd0}, DATA_WIDTH);
            end
            st_next[k + 1] = p;
        end

        p  = st_reg[DATA_WIDTH];
        qn = (p.a_neg != p.b[63]) ? 64'd0 - p.quo : p.quo;
        rn = p.a_neg ? 64'd0 - p.rem : p.rem;
        q  = sx(qn, DATA_WIDTH);
        r  = sx(rn, DATA_WIDTH);
        fl = (p.kind == K_DIVMOD || p.kind == K_MOD) && r != 64'd0 && r[63] != p.b[63];
        if (fl)
        begin
            r = sx(r + p.b, DATA_WIDTH);
            q = sx(q - 64'd1, DATA_WIDTH);
        end
        result_value_next = p.res;
        second_value_next = 64'd0;
        if (p.dv)
        begin
            case (p.kind)
                K_INTDIV: result_value_next = q;
                K_DIVMOD:
                begin
                    result_value_next = q;
                    second_value_next = r;
                end
                default:  result_value_next = r;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DATA_WIDTH; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        if (v_reg[DATA_WIDTH])
        begin
            result_value_reg   <= result_value_next;
            result_is_null_reg <= st_reg[DATA_WIDTH].isnull;
            second_value_reg   <= second_value_next;
            status_reg         <= st_reg[DATA_WIDTH].status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DATA_WIDTH; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < DATA_WIDTH; k++)
            begin
                v_reg[k + 1] <= v_reg[k];
            end
            done_reg <= v_reg[DATA_WIDTH];
        end
    end

    assign done           = done_reg;
    assign result_value   = result_value_reg;
    assign result_is_null = result_is_null_reg;
    assign second_value   = second_value_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

// ----- rtl/core/vm_integer_binary_alu.sv -----
// Top level of the integer binary ALU: front end, queue and execution pipeline.
// Depends on vibalu_pkg, vibalu_front, vibalu_queue and vibalu_back.
//
// A command is taken at a rising edge where start is high and busy is low.
// It carries kind, two signed operands and their null flags. Exactly one
// result word per command appears on result_value, result_is_null,
// second_value and status for one cycle, marked by done, in command order.
// After the accepting edge, a command passes through the queue, the decode
// register, DATA_WIDTH divider stages and one output register before done
// rises; the multiply finishes in the first divider stage.
// Every operation takes the same path, so one command is taken per cycle;
// the divider retires one quotient bit per stage and sets the depth.
// The queue drains every cycle, so busy stays low in normal use.
// The receiver cannot stall; every result is delivered the cycle it shows.
// Reset empties the queue and the pipeline; no result appears until a
// command has been taken after reset.
`default_nettype none

module vm_integer_binary_alu
    import vibalu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [4:0]  kind,
    input  wire logic [63:0] left_operand,
    input  wire logic [63:0] right_operand,
    input  wire logic        left_is_null,
    input  wire logic        right_is_null,
    output logic             done,
    output logic [63:0]      result_value,
    output logic             result_is_null,
    output logic [63:0]      second_value,
    output logic             status
);

    logic   push;
    logic   full;
    logic   empty;
    qword_t push_word;
    qword_t pop_word;

    vibalu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .start         (start),
        .full          (full),
        .kind          (kind),
        .left_operand  (left_operand),
        .right_operand (right_operand),
        .left_is_null  (left_is_null),
        .right_is_null (right_is_null),
        .push          (push),
        .word          (push_word)
    );

    vibalu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (!empty),
        .full      (full),
        .empty     (empty),
        .pop_word  (pop_word)
    );

    vibalu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (!empty),
        .in_word        (pop_word),
        .done           (done),
        .result_value   (result_value),
        .result_is_null (result_is_null),
        .second_value   (second_value),
        .status         (status)
    );

    assign busy = full;

endmodule

`default_nettype wire
